>>> rtl/core/aps_pkg.sv
// Package for the aging priority scheduler: queue depth, widths, codes
// and the structs shared by the top level and the cell row.
// Depends on nothing.
`default_nettype none

package aps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // request operations
  localparam logic OP_APPEND   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // result status codes
  localparam logic [1:0] ST_APPENDED   = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_AGING_STEP     = 2'd0;
  localparam logic [1:0] CFG_BEST_PRIORITY  = 2'd1;
  localparam logic [1:0] CFG_WORST_PRIORITY = 2'd2;

  typedef logic signed [7:0] prio_t;
  typedef logic signed [4:0] step_t;

  // one queue entry
  typedef struct packed {
    logic [7:0] task_id;
    prio_t      sprio;
    prio_t      dyn;
  } entry_t;

  // running-minimum token walking down the cell row
  typedef struct packed {
    logic             go;
    logic             found;
    prio_t            dyn;
    logic [IDX_W-1:0] idx;
    logic [7:0]       task_id;
    prio_t            sprio;
  } tok_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic             load;
    logic             update;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] win_idx;
    entry_t           new_entry;
    step_t            step;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/aging_priority_scheduler.sv
// Top level of the aging priority scheduler: request and result channels,
// configuration registers, sequencing and the row of aps_cell slots.
// Depends on aps_pkg and aps_cell.
`default_nettype none

// An append's result is registered at the accepting edge. A dispatch on a
// non-empty queue goes from acceptance through the scan state to the update
// state, which waits until the result register is free: a token carrying
// the running minimum walks the cell row one slot per cycle and the winner
// is latched as the token leaves the last cell, then the update state ages
// the passed-over entries, closes up the queue and registers the result.
// Requests are taken one at a time; a new request is accepted while a result
// is being taken at the same edge. Empty and full reports are registered at
// the accepting edge. Configuration writes are taken in every cycle.

module aging_priority_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_task_id,
  input  wire logic signed [7:0] in_priority_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_chosen_task,
  output logic signed [7:0] out_chosen_priority,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [aps_pkg::CNT_W-1:0] count_r, count_nxt;

  aps_pkg::step_t step_r;
  aps_pkg::prio_t best_r;
  logic [6:0]     worst_r;

  logic [aps_pkg::IDX_W-1:0] win_idx_r, win_idx_nxt;
  logic [7:0]                win_task_r, win_task_nxt;
  aps_pkg::prio_t            win_sprio_r, win_sprio_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [7:0]     out_task_r, out_task_nxt;
  aps_pkg::prio_t out_prio_r, out_prio_nxt;

  logic in_acc, out_free, is_full, is_empty;
  aps_pkg::prio_t worst_s, clamped;

  aps_pkg::cell_ctrl_t ctrl;
  aps_pkg::tok_t       tok_head;
  aps_pkg::tok_t       tok_chain [aps_pkg::QUEUE_DEPTH];
  aps_pkg::entry_t     nbr_chain [aps_pkg::QUEUE_DEPTH];

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign is_full   = count_r >= aps_pkg::CNT_W'(aps_pkg::QUEUE_DEPTH);
  assign is_empty  = count_r == '0;

  // clamp: below best wins over above worst when bounds cross
  assign worst_s = {1'b0, worst_r};
  always_comb begin
    if (in_priority_req < best_r) begin
      clamped = best_r;
    end else if (in_priority_req > worst_s) begin
      clamped = worst_s;
    end else begin
      clamped = in_priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= -5'sd1;
      best_r  <= -8'sd20;
      worst_r <= 7'd20;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aps_pkg::CFG_AGING_STEP:     step_r  <= cfg_wdata[4:0];
        aps_pkg::CFG_BEST_PRIORITY:  best_r  <= cfg_wdata;
        aps_pkg::CFG_WORST_PRIORITY: worst_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl                   = '0;
    ctrl.count             = count_r;
    ctrl.win_idx           = win_idx_r;
    ctrl.step              = step_r;
    ctrl.new_entry.task_id = in_task_id;
    ctrl.new_entry.sprio   = clamped;
    ctrl.new_entry.dyn     = clamped;
    ctrl.load   = in_acc && (in_operation == aps_pkg::OP_APPEND) && !is_full;
    ctrl.update = (state_r == S_UPD) && out_free;
  end

  // launch the search token into the head cell on an accepted dispatch
  always_comb begin
    tok_head    = '0;
    tok_head.go = in_acc && (in_operation == aps_pkg::OP_DISPATCH) && !is_empty;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    win_idx_nxt    = win_idx_r;
    win_task_nxt   = win_task_r;
    win_sprio_nxt  = win_sprio_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_prio_nxt   = out_prio_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == aps_pkg::OP_APPEND) begin
            out_valid_nxt = 1'b1;
            out_task_nxt  = '0;
            out_prio_nxt  = '0;
            if (is_full) begin
              out_status_nxt = aps_pkg::ST_FULL;
            end else begin
              out_status_nxt = aps_pkg::ST_APPENDED;
              count_nxt      = count_r + 1'b1;
            end
          end else if (is_empty) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = aps_pkg::ST_EMPTY;
            out_task_nxt   = '0;
            out_prio_nxt   = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // hold until the token leaves the last cell
        if (tok_chain[aps_pkg::QUEUE_DEPTH-1].go) begin
          win_idx_nxt   = tok_chain[aps_pkg::QUEUE_DEPTH-1].idx;
          win_task_nxt  = tok_chain[aps_pkg::QUEUE_DEPTH-1].task_id;
          win_sprio_nxt = tok_chain[aps_pkg::QUEUE_DEPTH-1].sprio;
          state_nxt     = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = aps_pkg::ST_DISPATCHED;
          out_task_nxt   = win_task_r;
          out_prio_nxt   = win_sprio_r;
          count_nxt      = count_r - 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_idx_r    <= win_idx_nxt;
    win_task_r   <= win_task_nxt;
    win_sprio_r  <= win_sprio_nxt;
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_prio_r   <= out_prio_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_chosen_task     = out_task_r;
  assign out_chosen_priority = out_prio_r;

  for (genvar i = 0; i < aps_pkg::QUEUE_DEPTH; i++) begin : g_cell
    aps_pkg::tok_t   tok_in_w;
    aps_pkg::entry_t nbr_in_w;

    if (i == 0) begin : g_head
      assign tok_in_w = tok_head;
    end else begin : g_body
      assign tok_in_w = tok_chain[i-1];
    end

    if (i == aps_pkg::QUEUE_DEPTH - 1) begin : g_tail
      assign nbr_in_w = '0;
    end else begin : g_mid
      assign nbr_in_w = nbr_chain[i+1];
    end

    aps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (aps_pkg::IDX_W'(i)),
      .ctrl     (ctrl),
      .nbr_in   (nbr_in_w),
      .nbr_out  (nbr_chain[i]),
      .tok_in   (tok_in_w),
      .tok_out  (tok_chain[i])
    );
  end

endmodule

`default_nettype wire

>>> rtl/core/aps_cell.sv
// One slot of the ready queue: holds an entry, forwards the minimum-search
// token to its neighbor and closes up or ages on a dispatch.
// Depends on aps_pkg.
`default_nettype none

module aps_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [aps_pkg::IDX_W-1:0] cell_idx,
  input  wire aps_pkg::cell_ctrl_t     ctrl,
  input  wire aps_pkg::entry_t         nbr_in,
  output aps_pkg::entry_t              nbr_out,
  input  wire aps_pkg::tok_t           tok_in,
  output aps_pkg::tok_t                tok_out
);

  aps_pkg::entry_t entry_r, entry_nxt;
  aps_pkg::tok_t   tok_r, tok_nxt;
  aps_pkg::prio_t  aged_dyn;
  logic signed [8:0] aged_sum;
  logic            occupied;
  logic            load_here;

  assign occupied  = aps_pkg::CNT_W'(cell_idx) < ctrl.count;
  assign load_here = ctrl.load && (ctrl.count == aps_pkg::CNT_W'(cell_idx));

  // saturating add of the aging step
  assign aged_sum = 9'(entry_r.dyn) + 9'(ctrl.step);
  always_comb begin
    if (aged_sum < -9'sd128) begin
      aged_dyn = -8'sd128;
    end else if (aged_sum > 9'sd127) begin
      aged_dyn = 8'sd127;
    end else begin
      aged_dyn = aged_sum[7:0];
    end
  end

  always_comb begin
    nbr_out     = entry_r;
    nbr_out.dyn = aged_dyn;
  end

  // strict less-than keeps the earlier entry on a tie
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.go && occupied && (!tok_in.found || entry_r.dyn < tok_in.dyn)) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.dyn     = entry_r.dyn;
      tok_nxt.idx     = cell_idx;
      tok_nxt.task_id = entry_r.task_id;
      tok_nxt.sprio   = entry_r.sprio;
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load && load_here) begin
      entry_nxt = ctrl.new_entry;
    end else if (ctrl.update) begin
      if (cell_idx >= ctrl.win_idx) begin
        entry_nxt = nbr_in;
      end else begin
        entry_nxt.dyn = aged_dyn;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

>>> rtl/core/aps_checker.sv
// Port-level checks for the aging priority scheduler, bound to the top.
// Depends on aps_pkg and aging_priority_scheduler.
`default_nettype none

module aps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_chosen_task,
  input wire logic [7:0]  out_chosen_priority
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_chosen_task) && $stable(out_chosen_priority))
    else $error("result changed while stalled");

  // only a dispatch carries a task and priority
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != aps_pkg::ST_DISPATCHED
      |-> out_chosen_task == 8'd0 && out_chosen_priority == 8'd0)
    else $error("non-dispatch result carries task fields");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a dispatch either reports an empty queue or closes the request side to scan
  a_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == aps_pkg::OP_DISPATCH
      |=> !in_ready || (out_valid && out_status == aps_pkg::ST_EMPTY))
    else $error("request taken during a dispatch scan");

endmodule

bind aging_priority_scheduler aps_checker u_aps_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
// Testbench for aging_priority_scheduler: a directed table, then random phases under
// changing register settings, results checked against the table or a ready-queue model.
// Depends on aps_pkg and the scheduler RTL.

module testbench;
  import aps_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_ROWS    = 9;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] task_id;
    prio_t      prio;
  } sched_result_t;

  typedef struct packed {
    logic          op;
    logic [7:0]    task_id;
    prio_t         prio_req;
    logic [4:0]    rep;
    logic          fixed_exp;
    sched_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [7:0]  in_task_id;
  prio_t       in_priority_req;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_chosen_task;
  prio_t       out_chosen_priority;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  // ready-queue model and its register copies
  logic [7:0]  q_task   [QUEUE_DEPTH];
  prio_t       q_static [QUEUE_DEPTH];
  prio_t       q_dyn    [QUEUE_DEPTH];
  int          q_count;
  step_t       cfg_step;
  prio_t       cfg_best;
  logic [6:0]  cfg_worst;

  sched_result_t pending_results [$];
  sched_result_t oldest;
  int            mismatch_count;
  int            cycle_count;
  bit            send_back_to_back;
  bit            take_every_cycle;
  bit            hold_results;

  // expected outcomes of the directed requests under the reset settings
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{OP_DISPATCH, 8'h00, 8'sd0,    5'd1,  1'b1, '{ST_EMPTY,      8'h00, 8'sd0}},
    '{OP_APPEND,   8'hFF, -8'sd128, 5'd1,  1'b1, '{ST_APPENDED,   8'h00, 8'sd0}},
    '{OP_APPEND,   8'h00, 8'sd127,  5'd1,  1'b1, '{ST_APPENDED,   8'h00, 8'sd0}},
    '{OP_APPEND,   8'hA5, 8'sd0,    5'd1,  1'b0, '{ST_APPENDED,   8'h00, 8'sd0}},
    '{OP_APPEND,   8'h5A, -8'sd20,  5'd1,  1'b0, '{ST_APPENDED,   8'h00, 8'sd0}},
    '{OP_APPEND,   8'h10, -8'sd5,   5'd12, 1'b0, '{ST_APPENDED,   8'h00, 8'sd0}},
    '{OP_APPEND,   8'h77, 8'sd3,    5'd1,  1'b1, '{ST_FULL,       8'h00, 8'sd0}},
    '{OP_DISPATCH, 8'h00, 8'sd0,    5'd1,  1'b1, '{ST_DISPATCHED, 8'hFF, -8'sd20}},
    '{OP_DISPATCH, 8'h3C, 8'sd9,    5'd1,  1'b1, '{ST_DISPATCHED, 8'h5A, -8'sd20}}
  };

  aging_priority_scheduler DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_task_id          (in_task_id),
    .in_priority_req     (in_priority_req),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_chosen_task     (out_chosen_task),
    .out_chosen_priority (out_chosen_priority),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Outcome of one request: clamp and append, or pick the lowest dynamic value,
  // age the rest with saturation and close up the queue.
  function automatic sched_result_t schedule_outcome(input logic op, input logic [7:0] tid,
                                                     input prio_t prq);
    sched_result_t res;
    int req, lo, hi, win, aged;
    res = '0;
    if (op == OP_APPEND) begin
      if (q_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        req = prq;
        lo  = cfg_best;
        hi  = cfg_worst;
        if (req < lo) req = lo;
        else if (req > hi) req = hi;
        q_task[q_count]   = tid;
        q_static[q_count] = prio_t'(req);
        q_dyn[q_count]    = prio_t'(req);
        q_count++;
        res.status = ST_APPENDED;
      end
    end else if (q_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      win = 0;
      for (int i = 1; i < q_count; i++)
        if (q_dyn[i] < q_dyn[win]) win = i;
      for (int i = 0; i < q_count; i++) begin
        if (i != win) begin
          aged = int'(q_dyn[i]) + int'(cfg_step);
          if (aged < -128) aged = -128;
          if (aged > 127) aged = 127;
          q_dyn[i] = prio_t'(aged);
        end
      end
      res.status  = ST_DISPATCHED;
      res.task_id = q_task[win];
      res.prio    = q_static[win];
      for (int i = win; i + 1 < q_count; i++) begin
        q_task[i]   = q_task[i + 1];
        q_static[i] = q_static[i + 1];
        q_dyn[i]    = q_dyn[i + 1];
      end
      q_count--;
    end
    return res;
  endfunction

  task automatic issue_request(input logic op, input logic [7:0] tid, input prio_t prq,
                               input bit fixed_exp, input sched_result_t fixed_res);
    int gap;
    sched_result_t pred;
    gap = send_back_to_back ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_task_id      <= tid;
    in_priority_req <= prq;
    do @(posedge clk); while (!in_ready);
    pred = schedule_outcome(op, tid, prq);
    pending_results.push_back(fixed_exp ? fixed_res : pred);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 4) @(posedge clk);
  endtask

  // hold valid across back-to-back writes; the caller lowers it
  task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_AGING_STEP:     cfg_step  = data[4:0];
      CFG_BEST_PRIORITY:  cfg_best  = data;
      CFG_WORST_PRIORITY: cfg_worst = data[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] step_w, input logic [7:0] best_w,
                           input logic [7:0] worst_w);
    write_register(CFG_AGING_STEP, step_w);
    write_register(CFG_BEST_PRIORITY, best_w);
    write_register(CFG_WORST_PRIORITY, worst_w);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result status %0d with no request pending", out_status));
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status)
          flag_error($sformatf("status got %0d want %0d", out_status, oldest.status));
        if (out_chosen_task !== oldest.task_id)
          flag_error($sformatf("chosen_task got %0d want %0d",
                               out_chosen_task, oldest.task_id));
        if (out_chosen_priority !== oldest.prio)
          flag_error($sformatf("chosen_priority got %0d want %0d",
                               out_chosen_priority, oldest.prio));
      end
    end
  end

  initial begin : result_taker
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        // long back-pressure: let the block fill and stall its input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        gap = take_every_cycle ? 0 : idle_length();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : request_sender
    logic [7:0] step_w, best_w, worst_w;
    logic       op;
    prio_t      prq;
    int         p_append;
    logic [7:0] phase_step  [5] = '{8'h08, 8'hF8, 8'hF0, 8'h0F, 8'h00};
    logic [7:0] phase_best  [5] = '{8'h80, 8'h00, 8'h7F, 8'h80, 8'hCE};
    logic [7:0] phase_worst [5] = '{8'h7F, 8'h00, 8'h80, 8'h00, 8'h3C};

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_operation      = OP_APPEND;
    in_task_id        = 8'h00;
    in_priority_req   = 8'sd0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_AGING_STEP;
    cfg_wdata         = 8'h00;
    mismatch_count    = 0;
    cycle_count       = 0;
    send_back_to_back = 1'b0;
    take_every_cycle  = 1'b0;
    hold_results      = 1'b0;
    q_count           = 0;
    cfg_step          = -5'sd1;
    cfg_best          = -8'sd20;
    cfg_worst         = 7'd20;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++)
      for (int k = 0; k < directed_rows[r].rep; k++)
        issue_request(directed_rows[r].op, directed_rows[r].task_id + 8'(k),
                      directed_rows[r].prio_req, directed_rows[r].fixed_exp,
                      directed_rows[r].want);
    in_valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drain();
      if (ph < 5) begin
        step_w  = phase_step[ph];
        best_w  = phase_best[ph];
        worst_w = phase_worst[ph];
      end else begin
        step_w  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 16) - 8)
                                              : 8'($urandom_range(0, 255));
        best_w  = ($urandom_range(0, 3) != 0) ? 8'(-$urandom_range(0, 128))
                                              : 8'($urandom_range(0, 255));
        worst_w = 8'($urandom_range(0, 255));
      end
      configure(step_w, best_w, worst_w);

      case (ph % 3)
        0:       p_append = 70;
        1:       p_append = 30;
        default: p_append = 50;
      endcase
      send_back_to_back = (ph == 3) || (ph == 6);
      take_every_cycle  = (ph == 6);
      if (ph == 3) hold_results = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < p_append) ? OP_APPEND : OP_DISPATCH;
        case ($urandom_range(0, 9))
          0:       prq = -8'sd128;
          1:       prq = 8'sd127;
          2:       prq = cfg_best;
          3:       prq = prio_t'({1'b0, cfg_worst});
          default: prq = prio_t'($urandom_range(0, 255));
        endcase
        issue_request(op, 8'($urandom_range(0, 255)), prq, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    wait_drain();
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
